// ----- hdl/jhdp_pkg.sv -----
package jhdp_pkg;

  typedef enum logic [3:0] {
    PH_SOI0     = 4'd0,
    PH_SOI1     = 4'd1,
    PH_SYNC     = 4'd2,
    PH_MARKER   = 4'd3,
    PH_LEN_HI   = 4'd4,
    PH_LEN_LO   = 4'd5,
    PH_SKIP     = 4'd6,
    PH_SOF_LHI  = 4'd7,
    PH_SOF_LLO  = 4'd8,
    PH_SOF_PREC = 4'd9,
    PH_H_HI     = 4'd10,
    PH_H_LO     = 4'd11,
    PH_W_HI     = 4'd12,
    PH_W_LO     = 4'd13,
    PH_IDLE     = 4'd14
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NOT_JPEG = 3'd1,
    ST_EOI      = 3'd2,
    ST_NO_DATA  = 3'd3,
    ST_SYNC     = 3'd4
  } status_e;

  localparam logic [7:0] ByteFf   = 8'hFF;
  localparam logic [7:0] MarkSoi  = 8'hD8;
  localparam logic [7:0] MarkSof0 = 8'hC0;
  localparam logic [7:0] MarkEoi  = 8'hD9;

  // one result from the parser toward the output register
  typedef struct packed {
    logic        emit;
    status_e     status;
    logic [15:0] height;
    logic [15:0] width;
  } result_t;

  // markers that carry a big-endian segment length
  function automatic logic marker_has_length(input logic [7:0] m);
    logic hit;
    hit = 1'b0;
    if (m >= 8'hC1 && m <= 8'hC7) hit = 1'b1;
    if (m >= 8'hC9 && m <= 8'hCB) hit = 1'b1;
    if (m >= 8'hCD && m <= 8'hCF) hit = 1'b1;
    if (m == 8'hDA || m == 8'hDB || m == 8'hDD) hit = 1'b1;
    if (m >= 8'hE0 && m <= 8'hEF) hit = 1'b1;
    if (m == 8'hFE) hit = 1'b1;
    return hit;
  endfunction

endpackage

// ----- hdl/jhdp_parser.sv -----
module jhdp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output jhdp_pkg::result_t result_o
);

  jhdp_pkg::phase_e phase_q, phase_d;
  logic [15:0] seg_rem_q, seg_rem_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] frame_h_q, frame_h_d;
  logic [7:0]  width_hi_q, width_hi_d;
  logic        sent_q, sent_d;

  logic [15:0] len;
  logic [15:0] seg_dec;

  assign len     = {len_hi_q, byte_i};
  assign seg_dec = seg_rem_q - 16'd1;

  always_comb begin
    phase_d    = phase_q;
    seg_rem_d  = seg_rem_q;
    len_hi_d   = len_hi_q;
    frame_h_d  = frame_h_q;
    width_hi_d = width_hi_q;
    sent_d     = sent_q;
    result_o   = '{emit: 1'b0, status: jhdp_pkg::ST_FOUND, height: 16'd0, width: 16'd0};

    if (!sent_q) begin
      case (phase_q)
        jhdp_pkg::PH_SOI0: begin
          if (byte_i == jhdp_pkg::ByteFf) phase_d = jhdp_pkg::PH_SOI1;
          else begin
            result_o.emit   = 1'b1;
            result_o.status = jhdp_pkg::ST_NOT_JPEG;
          end
        end
        jhdp_pkg::PH_SOI1: begin
          if (byte_i == jhdp_pkg::MarkSoi) phase_d = jhdp_pkg::PH_SYNC;
          else begin
            result_o.emit   = 1'b1;
            result_o.status = jhdp_pkg::ST_NOT_JPEG;
          end
        end
        jhdp_pkg::PH_SYNC: begin
          if (byte_i == jhdp_pkg::ByteFf) phase_d = jhdp_pkg::PH_MARKER;
          else begin
            result_o.emit   = 1'b1;
            result_o.status = jhdp_pkg::ST_SYNC;
          end
        end
        jhdp_pkg::PH_MARKER: begin
          if (byte_i == jhdp_pkg::MarkEoi) begin
            result_o.emit   = 1'b1;
            result_o.status = jhdp_pkg::ST_EOI;
          end else if (byte_i == jhdp_pkg::MarkSof0) begin
            phase_d = jhdp_pkg::PH_SOF_LHI;
          end else if (jhdp_pkg::marker_has_length(byte_i)) begin
            phase_d = jhdp_pkg::PH_LEN_HI;
          end else begin
            phase_d = jhdp_pkg::PH_SYNC;
          end
        end
        jhdp_pkg::PH_LEN_HI, jhdp_pkg::PH_SOF_LHI: begin
          // an ff here is already the sync of the next marker
          if (byte_i == jhdp_pkg::ByteFf) phase_d = jhdp_pkg::PH_MARKER;
          else begin
            len_hi_d = byte_i;
            phase_d  = (phase_q == jhdp_pkg::PH_LEN_HI) ? jhdp_pkg::PH_LEN_LO
                                                        : jhdp_pkg::PH_SOF_LLO;
          end
        end
        jhdp_pkg::PH_LEN_LO: begin
          if (len < 16'd2) begin
            result_o.emit   = 1'b1;
            result_o.status = jhdp_pkg::ST_SYNC;
          end else begin
            seg_rem_d = len - 16'd2;
            phase_d   = (len == 16'd2) ? jhdp_pkg::PH_SYNC : jhdp_pkg::PH_SKIP;
          end
        end
        jhdp_pkg::PH_SKIP: begin
          seg_rem_d = seg_dec;
          if (seg_dec == 16'd0) phase_d = jhdp_pkg::PH_SYNC;
        end
        jhdp_pkg::PH_SOF_LLO:  phase_d = jhdp_pkg::PH_SOF_PREC;
        jhdp_pkg::PH_SOF_PREC: phase_d = jhdp_pkg::PH_H_HI;
        jhdp_pkg::PH_H_HI: begin
          frame_h_d = {byte_i, 8'd0};
          phase_d   = jhdp_pkg::PH_H_LO;
        end
        jhdp_pkg::PH_H_LO: begin
          frame_h_d = {frame_h_q[15:8], byte_i};
          phase_d   = jhdp_pkg::PH_W_HI;
        end
        jhdp_pkg::PH_W_HI: begin
          width_hi_d = byte_i;
          phase_d    = jhdp_pkg::PH_W_LO;
        end
        jhdp_pkg::PH_W_LO: begin
          result_o.emit   = 1'b1;
          result_o.status = jhdp_pkg::ST_FOUND;
          result_o.height = frame_h_q;
          result_o.width  = {width_hi_q, byte_i};
        end
        default: ;
      endcase
      if (!result_o.emit && last_i) begin
        result_o.emit   = 1'b1;
        result_o.status = jhdp_pkg::ST_NO_DATA;
      end
    end

    if (result_o.emit) begin
      sent_d  = 1'b1;
      phase_d = jhdp_pkg::PH_IDLE;
    end

    // end of file rearms the parser
    if (last_i) begin
      phase_d    = jhdp_pkg::PH_SOI0;
      seg_rem_d  = 16'd0;
      len_hi_d   = 8'd0;
      frame_h_d  = 16'd0;
      width_hi_d = 8'd0;
      sent_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= jhdp_pkg::PH_SOI0;
      seg_rem_q  <= 16'd0;
      len_hi_q   <= 8'd0;
      frame_h_q  <= 16'd0;
      width_hi_q <= 8'd0;
      sent_q     <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      seg_rem_q  <= seg_rem_d;
      len_hi_q   <= len_hi_d;
      frame_h_q  <= frame_h_d;
      width_hi_q <= width_hi_d;
      sent_q     <= sent_d;
    end
  end

`ifndef ASSERT_OFF
  a_sent_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q |-> phase_q == jhdp_pkg::PH_IDLE)
    else $error("result sent but parser not idle");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == jhdp_pkg::PH_SKIP |-> seg_rem_q != 16'd0)
    else $error("skipping with empty segment count");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.emit && !last_i |=> sent_q)
    else $error("result not recorded");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == jhdp_pkg::PH_SOI0 && !sent_q)
    else $error("parser not rearmed after last byte");
`endif

endmodule

// ----- hdl/jpeg_header_dimension_parser.sv -----
// Byte-serial JPEG header parser: checks the SOI marker, walks marker segments and reports
// the SOF0 frame height and width, or an error status, once per file (the byte flagged by
// last_byte_i ends the file and rearms the parser). One byte is accepted every cycle while
// the input is not stalled; a byte waits in an input register, steps the parser from there,
// and any result that it gives is loaded into an output register. Input is stalled only while a byte waits
// in the input register and the output register holds a result that is not taken.
module jpeg_header_dimension_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] height_o,
  output logic [15:0] width_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q;
  logic [15:0] height_q;
  logic [15:0] width_q;

  logic in_accept;
  logic out_free;
  logic step;
  jhdp_pkg::result_t result;

  // output slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !step);
  assign out_valid_d = (step && result.emit) || (out_valid_q && out_stall_i);

  jhdp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (step && result.emit) begin
      status_q <= result.status;
      height_q <= result.height;
      width_q  <= result.width;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign height_o    = height_q;
  assign width_o     = width_q;

`ifndef ASSERT_OFF
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q))
    else $error("input register lost a request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(status_q))
    else $error("stalled result changed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> out_free)
    else $error("parser stepped into a full output register");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int  HalfPeriod = 6;
  localparam int  ResetCycles = 6;
  localparam int  LongHold = 80;
  localparam int  QuietLimit = 1000;
  localparam int  DrainCycles = 8;
  localparam int  MaxPrinted = 100;

  // markers used by the directed files
  localparam logic [7:0] MarkApp0 = 8'hE0;

  typedef struct packed {
    jhdp_pkg::status_e st;
    logic [15:0]       h;
    logic [15:0]       w;
  } frame_dims_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] height_o;
  logic [15:0] width_o;

  jpeg_header_dimension_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .height_o    (height_o),
    .width_o     (width_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // parser shadow state
  jhdp_pkg::phase_e ph_q;
  logic [15:0]      seg_left_q;
  logic [7:0]       len_hi_q;
  logic [15:0]      frame_h_q;
  logic [7:0]       w_hi_q;
  logic             done_q;

  frame_dims_t dims_due[$];
  frame_dims_t dims_want;
  logic [7:0]  file_bytes[$];

  int  mismatch_cnt = 0;
  int  parsed_cnt = 0;
  int  quiet_cycles = 0;
  int  sink_left = 0;
  int  hold_asks = 0;
  int  hold_seen = 0;
  bit  src_idle_en = 1'b0;
  bit  sink_idle_en = 1'b0;

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic logic has_seg_length(input logic [7:0] m);
    logic [3:0] lo;
    lo = m[3:0];
    case (m[7:4])
      4'hC:    return lo != 4'h0 && lo != 4'h8 && lo != 4'hC;
      4'hD:    return lo == 4'hA || lo == 4'hB || lo == 4'hD;
      4'hE:    return 1'b1;
      4'hF:    return lo == 4'hE;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_parser();
    ph_q       = jhdp_pkg::PH_SOI0;
    seg_left_q = '0;
    len_hi_q   = '0;
    frame_h_q  = '0;
    w_hi_q     = '0;
    done_q     = 1'b0;
  endtask

  // advance the shadow parser by one byte and queue any result
  task automatic parse_byte(input logic [7:0] b, input logic l);
    logic              hit;
    jhdp_pkg::status_e st;
    logic [15:0]       h;
    logic [15:0]       w;
    logic [15:0]       seg_len;
    hit = 1'b0;
    st  = jhdp_pkg::ST_FOUND;
    h   = '0;
    w   = '0;
    parsed_cnt++;
    if (!done_q) begin
      case (ph_q)
        jhdp_pkg::PH_SOI0: begin
          if (b == jhdp_pkg::ByteFf) ph_q = jhdp_pkg::PH_SOI1;
          else begin
            hit = 1'b1;
            st  = jhdp_pkg::ST_NOT_JPEG;
          end
        end
        jhdp_pkg::PH_SOI1: begin
          if (b == jhdp_pkg::MarkSoi) ph_q = jhdp_pkg::PH_SYNC;
          else begin
            hit = 1'b1;
            st  = jhdp_pkg::ST_NOT_JPEG;
          end
        end
        jhdp_pkg::PH_SYNC: begin
          if (b == jhdp_pkg::ByteFf) ph_q = jhdp_pkg::PH_MARKER;
          else begin
            hit = 1'b1;
            st  = jhdp_pkg::ST_SYNC;
          end
        end
        jhdp_pkg::PH_MARKER: begin
          if (b == jhdp_pkg::MarkEoi) begin
            hit = 1'b1;
            st  = jhdp_pkg::ST_EOI;
          end else if (b == jhdp_pkg::MarkSof0) ph_q = jhdp_pkg::PH_SOF_LHI;
          else if (has_seg_length(b)) ph_q = jhdp_pkg::PH_LEN_HI;
          else ph_q = jhdp_pkg::PH_SYNC;
        end
        jhdp_pkg::PH_LEN_HI, jhdp_pkg::PH_SOF_LHI: begin
          // an FF here is already the sync of the next marker
          if (b == jhdp_pkg::ByteFf) ph_q = jhdp_pkg::PH_MARKER;
          else begin
            len_hi_q = b;
            ph_q = (ph_q == jhdp_pkg::PH_LEN_HI) ? jhdp_pkg::PH_LEN_LO
                                                 : jhdp_pkg::PH_SOF_LLO;
          end
        end
        jhdp_pkg::PH_LEN_LO: begin
          seg_len = {len_hi_q, b};
          if (seg_len < 16'd2) begin
            hit = 1'b1;
            st  = jhdp_pkg::ST_SYNC;
          end else begin
            seg_left_q = seg_len - 16'd2;
            ph_q = (seg_left_q == 16'd0) ? jhdp_pkg::PH_SYNC : jhdp_pkg::PH_SKIP;
          end
        end
        jhdp_pkg::PH_SKIP: begin
          seg_left_q = seg_left_q - 16'd1;
          if (seg_left_q == 16'd0) ph_q = jhdp_pkg::PH_SYNC;
        end
        jhdp_pkg::PH_SOF_LLO:  ph_q = jhdp_pkg::PH_SOF_PREC;
        jhdp_pkg::PH_SOF_PREC: ph_q = jhdp_pkg::PH_H_HI;
        jhdp_pkg::PH_H_HI: begin
          frame_h_q = {b, 8'h00};
          ph_q = jhdp_pkg::PH_H_LO;
        end
        jhdp_pkg::PH_H_LO: begin
          frame_h_q = frame_h_q | {8'h00, b};
          ph_q = jhdp_pkg::PH_W_HI;
        end
        jhdp_pkg::PH_W_HI: begin
          w_hi_q = b;
          ph_q = jhdp_pkg::PH_W_LO;
        end
        jhdp_pkg::PH_W_LO: begin
          hit = 1'b1;
          st  = jhdp_pkg::ST_FOUND;
          h   = frame_h_q;
          w   = {w_hi_q, b};
        end
        default: ;
      endcase
      if (!hit && l) begin
        hit = 1'b1;
        st  = jhdp_pkg::ST_NO_DATA;
      end
    end
    if (hit) begin
      dims_due.push_back('{st: st, h: h, w: w});
      done_q = 1'b1;
      ph_q = jhdp_pkg::PH_IDLE;
    end
    if (l) clear_parser();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(b, l);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed header with random segments, some broken on purpose
  task automatic make_jpeg();
    int         plen;
    int         cut;
    logic [7:0] m;
    file_bytes.delete();
    file_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : jhdp_pkg::ByteFf);
    file_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : jhdp_pkg::MarkSoi);
    repeat ($urandom_range(0, 4)) begin
      file_bytes.push_back(($urandom_range(0, 30) == 0) ? 8'($urandom) : jhdp_pkg::ByteFf);
      if ($urandom_range(0, 3) == 0) begin
        // marker without a length, next byte must be a sync
        do m = 8'($urandom);
        while (has_seg_length(m) || m == jhdp_pkg::MarkSof0 || m == jhdp_pkg::MarkEoi);
        file_bytes.push_back(m);
      end else begin
        do m = 8'($urandom);
        while (!has_seg_length(m));
        file_bytes.push_back(m);
        case ($urandom_range(0, 19))
          0: ;  // segment without length
          1: begin
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'($urandom_range(0, 1)));
          end
          2: begin
            plen = $urandom_range(256, 276);
            file_bytes.push_back(plen[15:8]);
            file_bytes.push_back(plen[7:0]);
            repeat (plen - 2) file_bytes.push_back(8'($urandom));
          end
          default: begin
            plen = $urandom_range(2, 9);
            file_bytes.push_back(8'h00);
            file_bytes.push_back(plen[7:0]);
            repeat (plen - 2) file_bytes.push_back(8'($urandom));
          end
        endcase
      end
    end
    file_bytes.push_back(jhdp_pkg::ByteFf);
    if ($urandom_range(0, 7) == 0) file_bytes.push_back(jhdp_pkg::MarkEoi);
    else begin
      file_bytes.push_back(jhdp_pkg::MarkSof0);
      file_bytes.push_back(($urandom_range(0, 15) == 0) ? jhdp_pkg::ByteFf : 8'h00);
      file_bytes.push_back(8'($urandom));
      file_bytes.push_back(8'h08);
      repeat (4) file_bytes.push_back(edgy_byte());
    end
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  task automatic test_directed();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    file_bytes = '{8'h00};
    send_file();
    file_bytes = '{jhdp_pkg::ByteFf, 8'h00};
    send_file();
    // file ends right after the start marker
    file_bytes = '{jhdp_pkg::ByteFf, jhdp_pkg::MarkSoi};
    send_file();
    file_bytes = '{jhdp_pkg::ByteFf, jhdp_pkg::MarkSoi, jhdp_pkg::ByteFf, jhdp_pkg::MarkEoi};
    send_file();
    // length below two
    file_bytes = '{jhdp_pkg::ByteFf, jhdp_pkg::MarkSoi, jhdp_pkg::ByteFf, MarkApp0,
                   8'h00, 8'h01};
    send_file();
    // largest frame, then a trailing byte that is ignored
    file_bytes = '{jhdp_pkg::ByteFf, jhdp_pkg::MarkSoi, jhdp_pkg::ByteFf,
                   jhdp_pkg::MarkSof0, 8'h00, 8'h11, 8'h08,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55};
    send_file();
  endtask

  task automatic test_random_streams(input int n_items);
    int stop_at;
    stop_at = parsed_cnt + n_items;
    while (parsed_cnt < stop_at) begin
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 7) == 0) begin
        file_bytes.delete();
        repeat ($urandom_range(1, 5)) file_bytes.push_back(8'($urandom));
      end else make_jpeg();
      send_file();
    end
  endtask

  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (2) begin
      hold_asks <= hold_asks + 1;
      // one-byte files, each gives a result, so the pipe fills quickly
      repeat (30) begin
        file_bytes = '{8'($urandom)};
        send_file();
      end
    end
  endtask

  task automatic test_random_streams_noidle(input int n_items);
    int stop_at;
    stop_at = parsed_cnt + n_items;
    while (parsed_cnt < stop_at) begin
      make_jpeg();
      send_file();
    end
  endtask

  task automatic test_steady_stream(input int n_items);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_streams_noidle(n_items);
  endtask

  // receiver: random stall bursts, and a long hold when asked
  always @(posedge clk_i) begin
    if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen   <= hold_seen + 1;
      out_stall_i <= 1'b1;
      sink_left   <= LongHold - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      sink_left   <= $urandom_range(0, 9);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dims_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending, status %0d", status_o));
      end else begin
        dims_want = dims_due.pop_front();
        if (status_o !== dims_want.st)
          flag_mismatch($sformatf("status %0d, want %0d", status_o, dims_want.st));
        if (height_o !== dims_want.h)
          flag_mismatch($sformatf("height %0d, want %0d", height_o, dims_want.h));
        if (width_o !== dims_want.w)
          flag_mismatch($sformatf("width %0d, want %0d", width_o, dims_want.w));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_streams(1000);
    test_backpressure();
    test_steady_stream(350);
    in_valid_i <= 1'b0;
    while (dims_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && dims_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/jhdp_pkg.sv
hdl/jhdp_parser.sv
hdl/jpeg_header_dimension_parser.sv
tb/testbench.sv
